### rtl/core/palx_pkg.sv
// Shared types and constants of the palette RAM block: opcodes, RAM geometry,
// the controller-to-datapath command and the 5-to-8-bit channel expansion table.
// No dependencies.
package palx_pkg;

   localparam int RAM_BYTES = 64;
   localparam int ADDR_W    = $clog2(RAM_BYTES);

   localparam int REQ_W = 16;
   localparam int RSP_W = 32;

   localparam int AUTO_INC_BIT = 7;

   typedef enum logic [2:0] {
      OP_WR_INDEX = 3'd0,
      OP_RD_INDEX = 3'd1,
      OP_WR_DATA  = 3'd2,
      OP_RD_DATA  = 3'd3,
      OP_RD_COLOR = 3'd4
   } op_type;

   typedef struct packed {
      logic start;
      logic load;
   } palx_cmd_type;

   // floor(x * 255 / 31) for every 5-bit channel value
   localparam logic [7:0] EXPAND5_LUT [32] = '{
      8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
      8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
      8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
      8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
   };

endpackage

### rtl/core/palette_ram_rgb555_expand_core.sv
// Top level of the palette RAM block: index/data port and RGB555 color lookup.
// Depends on palx_pkg, palx_ctrl and palx_dp.
//
//   channel   direction  handshake              payload
//   req_*     in         req_tvalid/req_tready  req_tdata  (16 bits)
//   rsp_*     out        rsp_tvalid/rsp_tready  rsp_tdata  (32 bits)
//
// A request is accepted with the RAM read issued, then the RAM read data is loaded
// into the response register, and the response is held until rsp_tready.
// The next request is taken in the cycle after the response is accepted.
// Reset clears the index register and the per-byte valid flags; a byte never
// written reads as zero, so no clearing pass runs after reset.
module palette_ram_rgb555_expand_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // operation[2:0], value[10:3], palette[13:11], color_index[15:14]
   input  logic [palx_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // read_data[7:0], red[15:8], green[23:16], blue[31:24]
   output logic [palx_pkg::RSP_W-1:0]  rsp_tdata
);
   import palx_pkg::*;

   palx_cmd_type cmd;

   palx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   palx_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

### rtl/core/palx_ctrl.sv
// Controller of the palette RAM block: accepts one request, sequences the RAM
// read and the response hold. Depends on palx_pkg.
module palx_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output palx_pkg::palx_cmd_type cmd
);
   import palx_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SEND
   } state_type;

   state_type state_ff, state_in;
   logic      req_tready_ff, req_tready_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;

   always_comb begin
      state_in      = state_ff;
      req_tready_in = req_tready_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready_ff) begin
               state_in      = ST_EXEC;
               req_tready_in = 1'b0;
            end
         end
         ST_EXEC: begin
            state_in      = ST_SEND;
            rsp_tvalid_in = 1'b1;
         end
         ST_SEND: begin
            if (rsp_tready) begin
               state_in      = ST_IDLE;
               rsp_tvalid_in = 1'b0;
               req_tready_in = 1'b1;
            end
         end
         default: begin
            state_in      = ST_IDLE;
            req_tready_in = 1'b1;
            rsp_tvalid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         req_tready_ff <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         req_tready_ff <= req_tready_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = req_tready_ff;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign cmd.start  = req_tvalid && req_tready_ff && (state_ff == ST_IDLE);
   assign cmd.load   = (state_ff == ST_EXEC);

endmodule

### rtl/core/palx_dp.sv
// Datapath of the palette RAM block: index register, 64-byte palette RAM with
// per-byte valid flags, color word expansion and the response register.
// Depends on palx_pkg.
module palx_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  palx_pkg::palx_cmd_type      cmd,
   input  logic [palx_pkg::REQ_W-1:0]  req_tdata,
   output logic [palx_pkg::RSP_W-1:0]  rsp_tdata
);
   import palx_pkg::*;

   op_type              req_op;
   logic [7:0]          req_value;
   logic [2:0]          req_palette;
   logic [1:0]          req_color_index;

   op_type              op_ff;
   logic [7:0]          index_ff;
   logic [7:0]          mem [RAM_BYTES];
   logic [RAM_BYTES-1:0] valid_ff;

   logic [ADDR_W-1:0]   idx_addr;
   logic [5:0]          color_base;
   logic [ADDR_W-1:0]   addr_a;
   logic [ADDR_W-1:0]   addr_b;

   logic [7:0]          rd_a_ff;
   logic [7:0]          rd_b_ff;
   logic                val_a_ff;
   logic                val_b_ff;

   logic [7:0]          byte_a;
   logic [7:0]          byte_b;
   logic [15:0]         word;
   logic [RSP_W-1:0]    rsp_in;
   logic [RSP_W-1:0]    rsp_ff;

   assign req_op          = op_type'(req_tdata[2:0]);
   assign req_value       = req_tdata[10:3];
   assign req_palette     = req_tdata[13:11];
   assign req_color_index = req_tdata[15:14];

   assign idx_addr   = index_ff[ADDR_W-1:0];
   assign color_base = {req_palette, req_color_index, 1'b0};
   assign addr_a     = (req_op == OP_RD_DATA) ? idx_addr : color_base[ADDR_W-1:0];
   assign addr_b     = color_base[ADDR_W-1:0] + ADDR_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.start && (req_op == OP_WR_DATA)) begin
         mem[idx_addr] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rd_a_ff  <= mem[addr_a];
         rd_b_ff  <= mem[addr_b];
         val_a_ff <= valid_ff[addr_a];
         val_b_ff <= valid_ff[addr_b];
         op_ff    <= req_op;
      end
      if (cmd.load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         index_ff <= 8'd0;
      end else if (cmd.start) begin
         case (req_op)
            OP_WR_INDEX: begin
               index_ff <= req_value;
            end
            OP_WR_DATA: begin
               valid_ff[idx_addr] <= 1'b1;
               if (index_ff[AUTO_INC_BIT]) begin
                  index_ff[ADDR_W-1:0] <= idx_addr + ADDR_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign byte_a = val_a_ff ? rd_a_ff : 8'd0;
   assign byte_b = val_b_ff ? rd_b_ff : 8'd0;
   assign word   = {byte_b, byte_a};

   always_comb begin
      rsp_in = '0;
      unique case (op_ff)
         OP_RD_INDEX: rsp_in[7:0] = index_ff;
         OP_RD_DATA:  rsp_in[7:0] = byte_a;
         OP_RD_COLOR: begin
            rsp_in[15:8]  = EXPAND5_LUT[word[4:0]];
            rsp_in[23:16] = EXPAND5_LUT[word[9:5]];
            rsp_in[31:24] = EXPAND5_LUT[word[14:10]];
         end
         default: rsp_in = '0;
      endcase
   end

   assign rsp_tdata = rsp_ff;

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// Testbench for palette_ram_rgb555_expand_core: index/data port, auto-increment, color lookup.
// A local palette model predicts every response. Depends on palx_pkg and the core RTL.
module tb;
   import palx_pkg::*;

   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned DRAIN_CYCLES = 10;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] read_data;
   } palette_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   logic [7:0] shadow_ram [RAM_BYTES];
   logic [7:0] shadow_index = '0;
   palette_rsp_type palette_rsp_q [$];

   int unsigned mismatches = 0;
   int unsigned idle_cycles = 0;
   int unsigned burst_left = 0;
   bit req_gaps_on = 1'b0;
   bit rsp_stalls_on = 1'b0;
   int unsigned long_holds_requested = 0;
   int unsigned long_holds_done = 0;
   int unsigned hold_left = 0;
   logic [31:0] ready_pattern = '1;
   int unsigned pattern_pos = 0;
   int unsigned requests_seen = 0;
   int unsigned lookups_seen = 0;
   int unsigned data_writes_seen = 0;
   int unsigned responses_seen = 0;

   palette_ram_rgb555_expand_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < RAM_BYTES; i++) shadow_ram[i] = '0;
   end

   function automatic logic [7:0] widen_channel(input logic [4:0] x);
      int unsigned v;
      v = {27'd0, x};
      return 8'((v * 255) / 31);
   endfunction

   function automatic palette_rsp_type apply_palette_access(input logic [REQ_W-1:0] bits);
      palette_rsp_type rsp;
      logic [2:0] op;
      logic [7:0] value;
      int unsigned addr;
      int unsigned base;
      logic [15:0] word;
      op = bits[2:0];
      value = bits[10:3];
      rsp = '0;
      addr = shadow_index[5:0] % RAM_BYTES;
      case (op)
         OP_WR_INDEX: shadow_index = value;
         OP_RD_INDEX: rsp.read_data = shadow_index;
         OP_WR_DATA: begin
            shadow_ram[addr] = value;
            if (shadow_index[AUTO_INC_BIT]) begin
               shadow_index[5:0] = 6'((addr + 1) % RAM_BYTES);
            end
         end
         OP_RD_DATA: rsp.read_data = shadow_ram[addr];
         OP_RD_COLOR: begin
            base = bits[13:11] * 8 + bits[15:14] * 2;
            word = {shadow_ram[(base + 1) % RAM_BYTES], shadow_ram[base % RAM_BYTES]};
            rsp.red = widen_channel(word[4:0]);
            rsp.green = widen_channel(word[9:5]);
            rsp.blue = widen_channel(word[14:10]);
         end
         default: rsp = '0;
      endcase
      return rsp;
   endfunction

   // predict at request acceptance
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         palette_rsp_q.push_back(apply_palette_access(req_tdata));
         requests_seen++;
         if (req_tdata[2:0] == OP_RD_COLOR) lookups_seen++;
         if (req_tdata[2:0] == OP_WR_DATA) data_writes_seen++;
      end
   end

   task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
      if (exp !== act) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp, act);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      palette_rsp_type exp;
      palette_rsp_type act;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act = rsp_tdata;
         responses_seen++;
         if (palette_rsp_q.size() == 0) begin
            $error("unexpected response: tdata %h", rsp_tdata);
            mismatches++;
         end else begin
            exp = palette_rsp_q.pop_front();
            check_field("read_data", exp.read_data, act.read_data);
            check_field("red", exp.red, act.red);
            check_field("green", exp.green, act.green);
            check_field("blue", exp.blue, act.blue);
         end
      end
   end

   // response stall pattern, with long holds on demand
   always @(posedge clock) begin
      if (long_holds_done != long_holds_requested) begin
         long_holds_done <= long_holds_requested;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !rsp_stalls_on || ready_pattern[pattern_pos];
         if (pattern_pos == 31) begin
            pattern_pos <= 0;
            ready_pattern <= ($urandom_range(0, 3) == 0) ? $urandom() : ($urandom() | $urandom());
         end else begin
            pattern_pos <= pattern_pos + 1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_request(input logic [2:0] op, input logic [7:0] value,
                               input logic [2:0] pal, input logic [1:0] ci);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = req_gaps_on ? $urandom_range(1, 6) : 0;
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {ci, pal, value, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_lookup(input logic [2:0] pal, input logic [1:0] ci);
      send_request(OP_RD_COLOR, 8'($urandom()), pal, ci);
   endtask

   task automatic test_index_register();
      send_request(OP_WR_INDEX, 8'h00, 3'd0, 2'd0);
      send_request(OP_RD_INDEX, 8'hFF, 3'd7, 2'd3);
      send_request(OP_WR_INDEX, 8'hFF, 3'd7, 2'd3);
      send_request(OP_RD_INDEX, 8'h00, 3'd0, 2'd0);
      send_request(OP_WR_INDEX, 8'h40, 3'd0, 2'd0);
      send_request(OP_RD_INDEX, 8'h00, 3'd0, 2'd0);
   endtask

   task automatic test_data_port();
      send_request(OP_WR_INDEX, 8'h80, 3'd0, 2'd0);
      send_request(OP_WR_DATA, 8'hFF, 3'd0, 2'd0);
      send_request(OP_WR_DATA, 8'h00, 3'd0, 2'd0);
      send_request(OP_RD_DATA, 8'h00, 3'd0, 2'd0);
      send_request(OP_RD_DATA, 8'h00, 3'd0, 2'd0);
      // wrap at the top of the RAM, keeping bits 7:6
      send_request(OP_WR_INDEX, 8'hFF, 3'd0, 2'd0);
      send_request(OP_WR_DATA, 8'hFF, 3'd0, 2'd0);
      send_request(OP_RD_INDEX, 8'h00, 3'd0, 2'd0);
      send_request(OP_WR_INDEX, 8'h3F, 3'd0, 2'd0);
      send_request(OP_WR_DATA, 8'hFF, 3'd0, 2'd0);
      send_request(OP_RD_INDEX, 8'h00, 3'd0, 2'd0);
   endtask

   task automatic test_color_lookup();
      send_lookup(3'd7, 2'd3);
      send_lookup(3'd0, 2'd0);
      send_request(OP_WR_INDEX, 8'h81, 3'd0, 2'd0);
      send_request(OP_WR_DATA, 8'h7F, 3'd0, 2'd0);
      send_lookup(3'd0, 2'd0);
   endtask

   task automatic test_spare_ops();
      for (int op = int'(OP_SPARE_LO); op <= int'(OP_SPARE_HI); op++) begin
         send_request(3'(op), 8'($urandom()), 3'($urandom()), 2'($urandom()));
      end
   endtask

   task automatic test_random_traffic(input int unsigned n_items, input bit gaps,
                                      input bit stalls);
      int unsigned sent;
      int unsigned kind;
      int unsigned len;
      logic [7:0] start;
      req_gaps_on = gaps;
      rsp_stalls_on = stalls;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            start = {1'b1, 1'($urandom()), 6'($urandom())};
            len = $urandom_range(1, 16);
            send_request(OP_WR_INDEX, start, 3'($urandom()), 2'($urandom()));
            repeat (len) send_request(OP_WR_DATA, 8'($urandom()), 3'($urandom()),
                                      2'($urandom()));
            sent += len + 1;
            if ($urandom_range(0, 1) == 1) begin
               send_request(OP_RD_INDEX, 8'($urandom()), 3'($urandom()), 2'($urandom()));
               send_request(OP_WR_INDEX, {1'b0, start[6:0]}, 3'($urandom()), 2'($urandom()));
               send_request(OP_RD_DATA, 8'($urandom()), 3'($urandom()), 2'($urandom()));
               sent += 3;
            end
         end else if (kind < 70) begin
            len = $urandom_range(1, 8);
            repeat (len) send_lookup(3'($urandom()), 2'($urandom()));
            sent += len;
         end else if (kind < 95) begin
            send_request(3'($urandom_range(OP_RD_COLOR, OP_WR_INDEX)), 8'($urandom()),
                         3'($urandom()), 2'($urandom()));
            sent++;
         end else begin
            send_request(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), 8'($urandom()),
                         3'($urandom()), 2'($urandom()));
            sent++;
         end
      end
   endtask

   task automatic test_backpressure();
      long_holds_requested++;
      test_random_traffic(60, 1'b0, 1'b0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_index_register();
      test_data_port();
      test_color_lookup();
      test_spare_ops();
      test_random_traffic(300, 1'b0, 1'b0);
      test_random_traffic(1200, 1'b1, 1'b1);
      test_backpressure();
      test_random_traffic(340, 1'b1, 1'b0);
      req_tvalid <= 1'b0;
      while (palette_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests (%0d data writes, %0d color lookups), %0d responses checked",
               requests_seen, data_writes_seen, lookups_seen, responses_seen);
      $display("covered index/data port, auto-increment wrap, lookups, spare opcodes, stalls");
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
